[design/bpd_pkg.sv]
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int CMD_W      = 4;
    localparam int POS_W      = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_REAR  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_REAR   = 4'd3,
        CMD_INSERT_AT  = 4'd4,
        CMD_REMOVE_AT  = 4'd5,
        CMD_REPLACE_AT = 4'd6,
        CMD_READ_AT    = 4'd7,
        CMD_FIND       = 4'd8,
        CMD_CLEAR      = 4'd9
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } t_cell_op;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data_out;
        logic [INDEX_W-1:0]        index_out;
        logic [COUNT_W-1:0]        count;
    } t_out_word;

endpackage

[design/bpd_cell.sv]
`timescale 1ns / 1ps

module bpd_cell (
    input  logic                           i_clk,
    input  bpd_pkg::t_cell_op              i_op,
    input  logic [bpd_pkg::DATA_WIDTH-1:0] i_load,
    input  logic [bpd_pkg::DATA_WIDTH-1:0] i_prev,
    input  logic [bpd_pkg::DATA_WIDTH-1:0] i_next,
    input  logic [bpd_pkg::DATA_WIDTH-1:0] i_key,
    output logic [bpd_pkg::DATA_WIDTH-1:0] o_data,
    output logic                           o_match
);

    logic [bpd_pkg::DATA_WIDTH-1:0] r_data;
    logic [bpd_pkg::DATA_WIDTH-1:0] n_data;

    always_comb begin
        case (i_op)
            bpd_pkg::CELL_HOLD:      n_data = r_data;
            bpd_pkg::CELL_LOAD:      n_data = i_load;
            bpd_pkg::CELL_FROM_PREV: n_data = i_prev;
            bpd_pkg::CELL_FROM_NEXT: n_data = i_next;
            default:                 n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

[design/bounded_positional_deque.sv]
`timescale 1ns / 1ps
// channel   port prefix        payload          handshake
// in        i_in_  / o_in_     t_in_word        i_in_valid  / o_in_ready
// out       o_out_ / i_out_    t_out_word       o_out_valid / i_out_ready
//
// one word per cycle unless the output stalls: a command is decoded and
// applied to the cell row in the cycle it is taken, its result lands in the
// output register at that edge; the output register is the only buffer, so a
// stalled result holds o_in_ready low until it is taken
// synchronous active-low reset empties the list and the output register

module bounded_positional_deque (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpd_pkg::t_out_word o_out_word
);

    localparam int DEPTH = bpd_pkg::DEPTH;
    localparam int DW    = bpd_pkg::DATA_WIDTH;
    localparam int IW    = bpd_pkg::IDX_W;
    localparam int CW    = bpd_pkg::CNT_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    bpd_pkg::t_out_word  r_out_word;
    bpd_pkg::t_out_word  n_out_word;

    logic                fire;
    logic [DW-1:0]       key;
    logic [DW-1:0]       cell_data [DEPTH];
    logic [DEPTH-1:0]    cell_match;
    bpd_pkg::t_cell_op   cell_op   [DEPTH];

    logic                full;
    logic                do_ins;
    logic                do_rem;
    logic                do_wr;
    logic                have_data;
    logic                have_idx;
    logic [IW-1:0]       at;
    logic [IW-1:0]       rd_idx;
    logic [DW-1:0]       rd_data;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    bpd_pkg::t_status    status;

    assign fire       = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign key        = i_in_word.value[DW-1:0];
    assign full       = (r_count == CW'(DEPTH));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DW-1:0] prev_d;
            logic [DW-1:0] next_d;
            if (g == 0) begin : g_first
                assign prev_d = key;
            end else begin : g_mid
                assign prev_d = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_d = '0;
            end else begin : g_inner
                assign next_d = cell_data[g+1];
            end
            bpd_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op[g]),
                .i_load  (key),
                .i_prev  (prev_d),
                .i_next  (next_d),
                .i_key   (key),
                .o_data  (cell_data[g]),
                .o_match (cell_match[g])
            );
        end
    endgenerate

    // first live entry equal to the key
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i] && (CW'(i) < r_count)) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    always_comb begin
        status    = bpd_pkg::ST_OK;
        n_count   = r_count;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        do_wr     = 1'b0;
        have_data = 1'b0;
        have_idx  = 1'b0;
        at        = '0;
        rd_idx    = '0;
        case (i_in_word.cmd)
            bpd_pkg::CMD_PUSH_FRONT, bpd_pkg::CMD_PUSH_REAR: begin
                if (full) begin
                    status = bpd_pkg::ST_FULL;
                end else begin
                    if (i_in_word.cmd == bpd_pkg::CMD_PUSH_FRONT) begin
                        do_ins = 1'b1;
                    end else begin
                        do_wr = 1'b1;
                        at    = r_count[IW-1:0];
                    end
                    n_count = r_count + CW'(1);
                end
            end
            bpd_pkg::CMD_POP_FRONT, bpd_pkg::CMD_POP_REAR: begin
                if (r_count == '0) begin
                    status = bpd_pkg::ST_BAD;
                end else begin
                    have_data = 1'b1;
                    have_idx  = 1'b1;
                    if (i_in_word.cmd == bpd_pkg::CMD_POP_FRONT) begin
                        do_rem = 1'b1;
                    end else begin
                        rd_idx = IW'(r_count - CW'(1));
                    end
                    n_count = r_count - CW'(1);
                end
            end
            bpd_pkg::CMD_INSERT_AT: begin
                if (i_in_word.position > r_count) begin
                    status = bpd_pkg::ST_BAD;
                end else if (full) begin
                    status = bpd_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    at      = i_in_word.position[IW-1:0];
                    n_count = r_count + CW'(1);
                end
            end
            bpd_pkg::CMD_REMOVE_AT, bpd_pkg::CMD_REPLACE_AT, bpd_pkg::CMD_READ_AT: begin
                if (i_in_word.position >= r_count) begin
                    status = bpd_pkg::ST_BAD;
                end else if (i_in_word.cmd == bpd_pkg::CMD_REPLACE_AT) begin
                    do_wr = 1'b1;
                    at    = i_in_word.position[IW-1:0];
                end else begin
                    have_data = 1'b1;
                    have_idx  = 1'b1;
                    rd_idx    = i_in_word.position[IW-1:0];
                    at        = i_in_word.position[IW-1:0];
                    if (i_in_word.cmd == bpd_pkg::CMD_REMOVE_AT) begin
                        do_rem  = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            bpd_pkg::CMD_FIND: begin
                if (hit) begin
                    have_idx = 1'b1;
                    rd_idx   = hit_idx;
                end else begin
                    status = bpd_pkg::ST_MISS;
                end
            end
            bpd_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = bpd_pkg::ST_BAD;
            end
        endcase
    end

    // shift controls for the row
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_op[i] = bpd_pkg::CELL_HOLD;
            if (fire) begin
                if (do_ins) begin
                    if (IW'(i) == at) begin
                        cell_op[i] = bpd_pkg::CELL_LOAD;
                    end else if (IW'(i) > at) begin
                        cell_op[i] = bpd_pkg::CELL_FROM_PREV;
                    end
                end else if (do_rem) begin
                    if (IW'(i) >= at) begin
                        cell_op[i] = bpd_pkg::CELL_FROM_NEXT;
                    end
                end else if (do_wr && (IW'(i) == at)) begin
                    cell_op[i] = bpd_pkg::CELL_LOAD;
                end
            end
        end
    end

    assign rd_data = cell_data[rd_idx];

    always_comb begin
        n_out_word.status    = status;
        n_out_word.data_out  = have_data ? bpd_pkg::VALUE_W'(signed'(rd_data)) : '0;
        n_out_word.index_out = have_idx ? rd_idx : '0;
        n_out_word.count     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count <= n_count;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_PCT    = 6;
    localparam int HOLD_CYCLES = 48;
    localparam int TIMEOUT_NS  = 400000;

    localparam logic signed [bpd_pkg::VALUE_W-1:0] VAL_MAX =
        {1'b0, {(bpd_pkg::VALUE_W-1){1'b1}}};
    localparam logic signed [bpd_pkg::VALUE_W-1:0] VAL_MIN =
        {1'b1, {(bpd_pkg::VALUE_W-1){1'b0}}};

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    bpd_pkg::t_in_word  i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    bpd_pkg::t_out_word o_out_word;

    // shadow copy of the list, updated when a word is taken
    logic [bpd_pkg::DATA_WIDTH-1:0] list_slot [bpd_pkg::DEPTH];
    int                             list_len = 0;

    bpd_pkg::t_out_word pending_replies [$];

    int  mismatch_count     = 0;
    int  replies_checked    = 0;
    int  words_sent         = 0;
    int  times_full         = 0;
    int  status_tally [4]   = '{0, 0, 0, 0};
    int  stall_bursts_asked = 0;
    bit  calm_stretch       = 1'b0;
    bit  growing            = 1'b1;

    bounded_positional_deque u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    function automatic bpd_pkg::t_out_word apply_command(bpd_pkg::t_in_word w);
        bpd_pkg::t_out_word             r;
        logic [bpd_pkg::DATA_WIDTH-1:0] v;
        int                             p;
        int                             i;
        r        = '0;
        r.status = bpd_pkg::ST_OK;
        v        = w.value[bpd_pkg::DATA_WIDTH-1:0];
        p        = w.position;
        case (w.cmd)
            bpd_pkg::CMD_PUSH_FRONT, bpd_pkg::CMD_PUSH_REAR, bpd_pkg::CMD_INSERT_AT: begin
                if (w.cmd == bpd_pkg::CMD_PUSH_FRONT) p = 0;
                else if (w.cmd == bpd_pkg::CMD_PUSH_REAR) p = list_len;
                if (p > list_len) begin
                    r.status = bpd_pkg::ST_BAD;
                end else if (list_len >= bpd_pkg::DEPTH) begin
                    r.status = bpd_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--) list_slot[i] = list_slot[i-1];
                    list_slot[p] = v;
                    list_len++;
                    if (list_len == bpd_pkg::DEPTH) times_full++;
                end
            end
            bpd_pkg::CMD_POP_FRONT, bpd_pkg::CMD_POP_REAR,
            bpd_pkg::CMD_REMOVE_AT, bpd_pkg::CMD_READ_AT: begin
                if (w.cmd == bpd_pkg::CMD_POP_FRONT) p = 0;
                else if (w.cmd == bpd_pkg::CMD_POP_REAR) p = list_len - 1;
                if (list_len == 0 || p >= list_len) begin
                    r.status = bpd_pkg::ST_BAD;
                end else begin
                    r.data_out  = bpd_pkg::VALUE_W'($signed(list_slot[p]));
                    r.index_out = bpd_pkg::INDEX_W'(p);
                    if (w.cmd != bpd_pkg::CMD_READ_AT) begin
                        for (i = p; i < list_len - 1; i++) list_slot[i] = list_slot[i+1];
                        list_len--;
                    end
                end
            end
            bpd_pkg::CMD_REPLACE_AT: begin
                if (p >= list_len) r.status = bpd_pkg::ST_BAD;
                else list_slot[p] = v;
            end
            bpd_pkg::CMD_FIND: begin
                // scan from the rear so the front-most match wins
                r.status = bpd_pkg::ST_MISS;
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_slot[i] == v) begin
                        r.status    = bpd_pkg::ST_OK;
                        r.index_out = bpd_pkg::INDEX_W'(i);
                    end
                end
            end
            bpd_pkg::CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
                r.status = bpd_pkg::ST_BAD;
            end
        endcase
        r.count = bpd_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    function automatic bpd_pkg::t_in_word make_word(bpd_pkg::t_cmd c, int pos,
                                                    logic signed [bpd_pkg::VALUE_W-1:0] v);
        bpd_pkg::t_in_word w;
        w.cmd      = c;
        w.position = bpd_pkg::POS_W'(pos);
        w.value    = v;
        return w;
    endfunction

    // small values repeat often so find hits and duplicates show up
    function automatic logic signed [bpd_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return bpd_pkg::VALUE_W'(int'($urandom_range(7)) - 4);
            4: begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic bpd_pkg::t_in_word random_command(bit grow);
        bpd_pkg::t_in_word w;
        int                roll;
        int                kind;
        roll    = $urandom_range(99);
        kind    = $urandom_range(2);
        w.value = pick_value();
        if (roll < 1) begin
            w.cmd = bpd_pkg::CMD_CLEAR;
        end else if (roll < 3) begin
            w.cmd = bpd_pkg::CMD_W'($urandom_range({bpd_pkg::CMD_W{1'b1}},
                                                   bpd_pkg::CMD_CLEAR + 1));
        end else if (roll < (grow ? 60 : 20)) begin
            w.cmd = kind == 0 ? bpd_pkg::CMD_PUSH_FRONT :
                    kind == 1 ? bpd_pkg::CMD_PUSH_REAR : bpd_pkg::CMD_INSERT_AT;
        end else if (roll < (grow ? 72 : 68)) begin
            w.cmd = kind == 0 ? bpd_pkg::CMD_POP_FRONT :
                    kind == 1 ? bpd_pkg::CMD_POP_REAR : bpd_pkg::CMD_REMOVE_AT;
        end else begin
            w.cmd = kind == 0 ? bpd_pkg::CMD_REPLACE_AT :
                    kind == 1 ? bpd_pkg::CMD_READ_AT : bpd_pkg::CMD_FIND;
        end
        if ($urandom_range(9) == 0) begin
            w.position = bpd_pkg::POS_W'($urandom);
        end else if (w.cmd == bpd_pkg::CMD_INSERT_AT) begin
            w.position = bpd_pkg::POS_W'($urandom_range(list_len));
        end else begin
            w.position = list_len == 0 ? '0 : bpd_pkg::POS_W'($urandom_range(list_len - 1));
        end
        if (w.cmd == bpd_pkg::CMD_FIND && list_len > 0 && $urandom_range(1) == 1) begin
            w.value = $signed(list_slot[$urandom_range(list_len - 1)]);
        end
        return w;
    endfunction

    // called at a rising edge, returns at the edge where the word is taken
    task automatic send_word(bpd_pkg::t_in_word w);
        bpd_pkg::t_out_word r;
        if (!calm_stretch) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = apply_command(w);
        pending_replies.push_back(r);
        status_tally[r.status]++;
        words_sent++;
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic run_random(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if (list_len == bpd_pkg::DEPTH) growing = 1'b0;
            else if (list_len == 0) growing = 1'b1;
            else if ($urandom_range(49) == 0) growing = ~growing;
            send_word(random_command(growing));
        end
    endtask

    task automatic test_empty_list();
        send_word(make_word(bpd_pkg::CMD_POP_FRONT, 0, 0));
        send_word(make_word(bpd_pkg::CMD_POP_REAR, 0, 0));
        send_word(make_word(bpd_pkg::CMD_READ_AT, 0, 0));
        send_word(make_word(bpd_pkg::CMD_REMOVE_AT, 0, 0));
        send_word(make_word(bpd_pkg::CMD_REPLACE_AT, 0, 7));
        send_word(make_word(bpd_pkg::CMD_FIND, 0, 0));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, 1, 3));
        send_word(make_word(bpd_pkg::t_cmd'(bpd_pkg::CMD_CLEAR + 1), 0, 0));
        send_word(make_word(bpd_pkg::t_cmd'({bpd_pkg::CMD_W{1'b1}}), 0, 0));
    endtask

    task automatic test_edge_values();
        send_word(make_word(bpd_pkg::CMD_PUSH_FRONT, 0, VAL_MAX));
        send_word(make_word(bpd_pkg::CMD_PUSH_REAR, 0, VAL_MIN));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, 1, -1));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, 3, 0));
        send_word(make_word(bpd_pkg::CMD_READ_AT, 2, 0));
        send_word(make_word(bpd_pkg::CMD_REPLACE_AT, 1, 5));
        send_word(make_word(bpd_pkg::CMD_FIND, 0, 5));
        send_word(make_word(bpd_pkg::CMD_FIND, 0, -1));
        send_word(make_word(bpd_pkg::CMD_REMOVE_AT, 0, 0));
        send_word(make_word(bpd_pkg::CMD_READ_AT, {bpd_pkg::POS_W{1'b1}}, 0));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, {bpd_pkg::POS_W{1'b1}}, 9));
        send_word(make_word(bpd_pkg::CMD_POP_FRONT, 0, 0));
        send_word(make_word(bpd_pkg::CMD_POP_REAR, 0, 0));
        send_word(make_word(bpd_pkg::CMD_CLEAR, 0, 0));
    endtask

    // receiver holds off while the list is filled, so the input stalls
    task automatic test_full_list();
        send_word(make_word(bpd_pkg::CMD_CLEAR, 0, 0));
        stall_bursts_asked++;
        while (list_len < bpd_pkg::DEPTH) begin
            send_word(make_word($urandom_range(1) ? bpd_pkg::CMD_PUSH_FRONT
                                                  : bpd_pkg::CMD_PUSH_REAR, 0,
                                pick_value()));
        end
        send_word(make_word(bpd_pkg::CMD_PUSH_FRONT, 0, 1));
        send_word(make_word(bpd_pkg::CMD_PUSH_REAR, 0, 2));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, bpd_pkg::DEPTH, 3));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, 0, 4));
        send_word(make_word(bpd_pkg::CMD_INSERT_AT, bpd_pkg::DEPTH + 1, 5));
        send_word(make_word(bpd_pkg::CMD_FIND, 0, $signed(list_slot[bpd_pkg::DEPTH-1])));
        send_word(make_word(bpd_pkg::CMD_READ_AT, bpd_pkg::DEPTH - 1, 0));
        send_word(make_word(bpd_pkg::CMD_REPLACE_AT, bpd_pkg::DEPTH - 1, VAL_MIN));
        send_word(make_word(bpd_pkg::CMD_REMOVE_AT, bpd_pkg::DEPTH, 0));
        send_word(make_word(bpd_pkg::CMD_REMOVE_AT, bpd_pkg::DEPTH - 1, 0));
        send_word(make_word(bpd_pkg::CMD_POP_REAR, 0, 0));
    endtask

    task automatic test_random_mix();
        run_random(700);
    endtask

    task automatic test_back_to_back();
        calm_stretch = 1'b1;
        run_random(200);
        calm_stretch = 1'b0;
    endtask

    task automatic test_drain_pause();
        int b;
        for (b = 0; b < 8; b++) begin
            run_random($urandom_range(30, 5));
            wait_for_replies();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_mix();
        test_back_to_back();
        test_drain_pause();
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        $display("%0d words sent, %0d replies checked, list full %0d times",
                 words_sent, replies_checked, times_full);
        $display("status ok %0d, bad %0d, full %0d, not found %0d",
                 status_tally[bpd_pkg::ST_OK], status_tally[bpd_pkg::ST_BAD],
                 status_tally[bpd_pkg::ST_FULL], status_tally[bpd_pkg::ST_MISS]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d replies outstanding", pending_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : reply_side
        int hold_left;
        int bursts_served;
        hold_left     = 0;
        bursts_served = 0;
        forever begin
            @(posedge i_clk);
            if (bursts_served < stall_bursts_asked) begin
                bursts_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (calm_stretch) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic compare_field(string name, logic [bpd_pkg::VALUE_W-1:0] want,
                                 logic [bpd_pkg::VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_reply
        bpd_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with nothing expected, got %p", $time, o_out_word);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("status", bpd_pkg::VALUE_W'(want.status),
                              bpd_pkg::VALUE_W'(o_out_word.status));
                compare_field("data_out", want.data_out, o_out_word.data_out);
                compare_field("index_out", bpd_pkg::VALUE_W'(want.index_out),
                              bpd_pkg::VALUE_W'(o_out_word.index_out));
                compare_field("count", bpd_pkg::VALUE_W'(want.count),
                              bpd_pkg::VALUE_W'(o_out_word.count));
                replies_checked++;
            end
        end
    end

endmodule

[sim.f]
design/bpd_pkg.sv
design/bpd_cell.sv
design/bounded_positional_deque.sv
bench/testbench.sv
